// ===== hdl/i2cm_pkg.sv =====
`default_nettype none
package i2cm_pkg;

	localparam int PHASE_W = 16;
	localparam int IDX_W   = 5;
	localparam int BYTE_W  = 8;
	localparam int IN_W    = 24;
	localparam int OUT_W   = 16;

	localparam logic [PHASE_W-1:0] PHASE_RESET = 16'd250;
	localparam logic [IDX_W-1:0]   BIT_PHASES  = 5'd16;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_STOP  = 2'd1,
		MODE_WRITE = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	typedef struct packed {
		logic scl;
		logic sda;
		logic last;
	} phase_t;

	function automatic phase_t phase_of(mode_t mode, logic [IDX_W-1:0] idx,
			logic data_bit, logic drive);
		phase_t p;
		p = '{scl: 1'b1, sda: 1'b1, last: 1'b1};
		case (mode)
			MODE_START: begin
				case (idx)
					5'd0:    p = '{scl: 1'b1, sda: 1'b1, last: 1'b0};
					5'd1:    p = '{scl: 1'b1, sda: 1'b0, last: 1'b0};
					default: p = '{scl: 1'b0, sda: 1'b0, last: 1'b1};
				endcase
			end
			MODE_STOP: begin
				if (idx == 5'd0)
					p = '{scl: 1'b1, sda: 1'b0, last: 1'b0};
				else
					p = '{scl: 1'b1, sda: 1'b1, last: 1'b1};
			end
			MODE_WRITE: begin
				if (idx < BIT_PHASES)
					p = '{scl: idx[0], sda: data_bit, last: 1'b0};
				else if (idx == 5'd16)
					p = '{scl: 1'b0, sda: 1'b1, last: 1'b0};
				else if (idx == 5'd17)
					p = '{scl: 1'b1, sda: 1'b1, last: 1'b0};
				else
					p = '{scl: 1'b0, sda: 1'b1, last: 1'b1};
			end
			default: begin
				if (idx == 5'd0)
					p = '{scl: 1'b0, sda: 1'b1, last: 1'b0};
				else if (idx <= BIT_PHASES)
					p = '{scl: idx[0], sda: 1'b1, last: 1'b0};
				else if (idx == 5'd17)
					p = '{scl: 1'b0, sda: drive, last: 1'b0};
				else if (idx == 5'd18)
					p = '{scl: 1'b1, sda: drive, last: 1'b0};
				else
					p = '{scl: 1'b0, sda: drive, last: 1'b1};
			end
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/i2cm_phase_timer.sv =====
`default_nettype none
module i2cm_phase_timer (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         load,
	input  wire logic [i2cm_pkg::PHASE_W-1:0] period,
	output logic                              done
);
	import i2cm_pkg::*;

	logic [PHASE_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= (period == '0) ? PHASE_W'(1) : period;
		end else if (cnt_q > PHASE_W'(1)) begin
			cnt_q <= cnt_q - PHASE_W'(1);
		end
	end

	assign done = (cnt_q == PHASE_W'(1));

endmodule
`default_nettype wire

// ===== hdl/i2c_master_byte_engine.sv =====
// Each bus phase is held by one down counter, then goes out as a beat.
// A new command is accepted only while the sequencer is idle, after the previous command's last phase has gone out.
// Each command runs N = 3/2/19/20 phases
// (start/stop/write/read); output stalls stretch the phase that waits.
// Reset: sequencer idle, no beat pending, phase_cycles = 250.
`default_nettype none
module i2c_master_byte_engine (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [i2cm_pkg::PHASE_W-1:0] cfg_data,     // phase_cycles
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [i2cm_pkg::IN_W-1:0]    s_tdata,      // write_byte, send_ack, slave_byte, slave_ack
	input  wire logic [1:0]                   s_tuser,      // mode
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [i2cm_pkg::OUT_W-1:0]        m_tdata,      // scl, sda, read_byte, nack_seen
	output logic                              m_tlast
);
	import i2cm_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RUN  = 2'b10
	} state_t;

	state_t             state_q;
	logic [PHASE_W-1:0] phase_q;
	mode_t              mode_q;
	logic [IDX_W-1:0]   idx_q;
	logic [BYTE_W-1:0]  sh_q;
	logic [BYTE_W-1:0]  acc_q;
	logic               drive_q;
	logic               sack_q;
	logic               m_tvalid_q;
	logic [OUT_W-1:0]   m_tdata_q;
	logic               m_tlast_q;

	logic   accept;
	logic   tmr_done;
	logic   slot_free;
	logic   emit;
	logic   tmr_load;
	phase_t ph;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign slot_free = !m_tvalid_q || m_tready;
	assign emit      = (state_q == S_RUN) && tmr_done && slot_free;
	assign ph        = phase_of(mode_q, idx_q, sh_q[BYTE_W-1], drive_q);
	assign tmr_load  = accept || (emit && !ph.last);

	i2cm_phase_timer u_timer (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (tmr_load),
		.period (phase_q),
		.done   (tmr_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			phase_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RUN;
						idx_q   <= '0;
					end
				end
				S_RUN: begin
					if (emit) begin
						if (ph.last)
							state_q <= S_IDLE;
						else
							idx_q <= idx_q + IDX_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= mode_t'(s_tuser);
			drive_q <= !s_tdata[8];
			sack_q  <= s_tdata[17];
			acc_q   <= '0;
			if (mode_t'(s_tuser) == MODE_READ)
				sh_q <= s_tdata[16:9];
			else
				sh_q <= s_tdata[7:0];
		end else if (emit && idx_q[0] && (idx_q < BIT_PHASES)) begin
			acc_q <= {acc_q[BYTE_W-2:0], sh_q[BYTE_W-1]};
			sh_q  <= {sh_q[BYTE_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tlast_q <= ph.last;
			m_tdata_q <= {5'd0,
				ph.last && (mode_q == MODE_WRITE) && sack_q,
				(ph.last && (mode_q == MODE_READ)) ? acc_q : 8'd0,
				ph.sda, ph.scl};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		emit && ph.last |=> state_q == S_IDLE)
		else $error("sequencer did not return to idle after final phase");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN |-> idx_q <= 5'd19)
		else $error("phase index out of range");

	a_nack_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[10] |-> m_tlast)
		else $error("nack flag on a non-final phase");

	a_rbyte_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[9:2] != 8'd0) |-> m_tlast)
		else $error("read byte on a non-final phase");

endmodule
`default_nettype wire

// ===== tb/i2c_master_byte_engine_tb.sv =====
`timescale 1ns / 1ps
module i2c_master_byte_engine_tb;
	import i2cm_pkg::*;

	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 20;
	localparam int RAND_PER_LEN = 43;

	typedef struct {
		mode_t      mode;
		logic [7:0] wr_byte;
		logic       ack_out;
		logic [7:0] slv_byte;
		logic       slv_ack;
		logic       typed;
		logic [7:0] t_rb;
		logic       t_nack;
	} bus_cmd_t;

	typedef struct {
		logic       scl;
		logic       sda;
		logic       last;
		logic [7:0] rb;
		logic       nack;
	} bus_phase_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [PHASE_W-1:0]  cfg_data = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata = '0;   // write_byte, send_ack, slave_byte, slave_ack
	logic [1:0]          s_tuser = '0;   // mode
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;        // scl, sda, read_byte, nack_seen
	logic                m_tlast;

	bus_phase_t          expected_phases[$];
	int                  mismatches = 0;
	int                  cycles = 0;
	logic                steady = 1'b0;
	logic                hold_req = 1'b0;
	logic                hold_ack = 1'b0;
	int                  hold_left = 0;

	// typed results: read_byte / nack_seen on the closing beat
	bus_cmd_t directed_cmds [0:19] = '{
		'{MODE_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0},
		'{MODE_STOP,  8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0},
		'{MODE_WRITE, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0},
		'{MODE_WRITE, 8'hFF, 1'b0, 8'h00, 1'b1, 1'b1, 8'h00, 1'b1},
		'{MODE_WRITE, 8'hA5, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
		'{MODE_WRITE, 8'h5A, 1'b1, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b1},
		'{MODE_READ,  8'h00, 1'b1, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0},
		'{MODE_READ,  8'h00, 1'b0, 8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0},
		'{MODE_READ,  8'h00, 1'b1, 8'h80, 1'b0, 1'b1, 8'h80, 1'b0},
		'{MODE_READ,  8'h00, 1'b0, 8'h01, 1'b0, 1'b1, 8'h01, 1'b0},
		'{MODE_READ,  8'hFF, 1'b1, 8'h3C, 1'b1, 1'b1, 8'h3C, 1'b0},
		'{MODE_START, 8'hFF, 1'b1, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b0},
		'{MODE_STOP,  8'hFF, 1'b1, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b0},
		'{MODE_WRITE, 8'h80, 1'b1, 8'h55, 1'b0, 1'b0, 8'h00, 1'b0},
		'{MODE_WRITE, 8'h01, 1'b0, 8'hAA, 1'b1, 1'b0, 8'h00, 1'b0},
		'{MODE_READ,  8'h12, 1'b0, 8'hC3, 1'b1, 1'b0, 8'h00, 1'b0},
		'{MODE_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
		'{MODE_WRITE, 8'h6E, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
		'{MODE_READ,  8'h00, 1'b1, 8'h9B, 1'b0, 1'b0, 8'h00, 1'b0},
		'{MODE_STOP,  8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0}
	};

	i2c_master_byte_engine u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic bus_phase_t bus_phase(input logic scl, input logic sda);
		bus_phase_t p;
		p = '{scl: scl, sda: sda, last: 1'b0, rb: 8'h00, nack: 1'b0};
		return p;
	endfunction

	task automatic predict_bus_phases(input bus_cmd_t c);
		bus_phase_t run[$];
		logic       drv;
		int         n;
		drv = ~c.ack_out;
		case (c.mode)
			MODE_START: begin
				run.push_back(bus_phase(1'b1, 1'b1));
				run.push_back(bus_phase(1'b1, 1'b0));
				run.push_back(bus_phase(1'b0, 1'b0));
			end
			MODE_STOP: begin
				run.push_back(bus_phase(1'b1, 1'b0));
				run.push_back(bus_phase(1'b1, 1'b1));
			end
			MODE_WRITE: begin
				for (int i = 7; i >= 0; i--) begin
					run.push_back(bus_phase(1'b0, c.wr_byte[i]));
					run.push_back(bus_phase(1'b1, c.wr_byte[i]));
				end
				run.push_back(bus_phase(1'b0, 1'b1));
				run.push_back(bus_phase(1'b1, 1'b1));
				run.push_back(bus_phase(1'b0, 1'b1));
			end
			default: begin
				run.push_back(bus_phase(1'b0, 1'b1));
				for (int i = 0; i < 8; i++) begin
					run.push_back(bus_phase(1'b1, 1'b1));
					run.push_back(bus_phase(1'b0, 1'b1));
				end
				run.push_back(bus_phase(1'b0, drv));
				run.push_back(bus_phase(1'b1, drv));
				run.push_back(bus_phase(1'b0, drv));
			end
		endcase
		n = run.size() - 1;
		run[n].last = 1'b1;
		if (c.mode == MODE_WRITE)
			run[n].nack = c.slv_ack;
		if (c.mode == MODE_READ)
			run[n].rb = c.slv_byte;
		if (c.typed) begin
			run[n].rb = c.t_rb;
			run[n].nack = c.t_nack;
		end
		foreach (run[i])
			expected_phases.push_back(run[i]);
	endtask

	task automatic send_cmd(input bus_cmd_t c);
		if (!steady && $urandom_range(99) < 31) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 31);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, c.slv_ack, c.slv_byte, c.ack_out, c.wr_byte};
		s_tuser <= c.mode;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_bus_phases(c);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_phases.size() != 0) @(posedge clk);
	endtask

	task automatic write_phase_cycles(input logic [PHASE_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic bus_cmd_t random_cmd();
		bus_cmd_t c;
		c.mode = mode_t'($urandom_range(3));
		c.wr_byte = 8'($urandom_range(255));
		c.ack_out = 1'($urandom_range(1));
		c.slv_byte = 8'($urandom_range(255));
		c.slv_ack = 1'($urandom_range(1));
		c.typed = 1'b0;
		c.t_rb = 8'h00;
		c.t_nack = 1'b0;
		return c;
	endfunction

	// receiver: random stalls, one long hold on request
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady || ($urandom_range(99) >= 31);
		end
	end

	always @(posedge clk) begin
		bus_phase_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_phases.size() == 0) begin
				$error("beat with no phase expected: tdata %h tlast %b", m_tdata, m_tlast);
				mismatches <= mismatches + 1;
			end else begin
				e = expected_phases.pop_front();
				if (m_tdata[0] !== e.scl || m_tdata[1] !== e.sda || m_tlast !== e.last ||
						m_tdata[9:2] !== e.rb || m_tdata[10] !== e.nack)
					mismatches <= mismatches + 1;
				if (m_tdata[0] !== e.scl)
					$error("scl: expected %0d, got %0d", e.scl, m_tdata[0]);
				if (m_tdata[1] !== e.sda)
					$error("sda: expected %0d, got %0d", e.sda, m_tdata[1]);
				if (m_tlast !== e.last)
					$error("last: expected %0d, got %0d", e.last, m_tlast);
				if (m_tdata[9:2] !== e.rb)
					$error("read_byte: expected %h, got %h", e.rb, m_tdata[9:2]);
				if (m_tdata[10] !== e.nack)
					$error("nack_seen: expected %0d, got %0d", e.nack, m_tdata[10]);
			end
		end
	end

	initial begin
		bus_cmd_t           c;
		logic [PHASE_W-1:0] rand_lens [0:5];
		rand_lens = '{16'd1, 16'd0, 16'd2, 16'd1, 16'd5, 16'd3};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_cmds[i])
			send_cmd(directed_cmds[i]);
		settle();

		// longest phase, shortest command
		write_phase_cycles(16'hFFFF);
		c = '{MODE_STOP, 8'hFF, 1'b1, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b0};
		send_cmd(c);
		settle();

		for (int k = 0; k < 6; k++) begin
			write_phase_cycles(rand_lens[k]);
			steady <= (k == 3);
			for (int i = 0; i < RAND_PER_LEN; i++) begin
				if (k == 1 && i == 8)
					hold_req <= ~hold_req;
				send_cmd(random_cmd());
			end
			settle();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_phases.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/i2cm_pkg.sv
hdl/i2cm_phase_timer.sv
hdl/i2c_master_byte_engine.sv
tb/i2c_master_byte_engine_tb.sv
